// ===== sv/avsu_pkg.sv =====
// Shared types and constants of the volume and stereo up-mix unit.
package avsu_pkg;

  localparam int unsigned MaxChannels = 8;
  localparam int unsigned RingMax     = 131072;
  localparam int unsigned CfgAddrW    = 4;
  localparam int unsigned CfgDataW    = 32;

  typedef enum logic [1:0] {
    FmtS16 = 2'd0,
    FmtU8  = 2'd1,
    FmtS8  = 2'd2
  } sample_fmt_e;

  typedef enum logic [1:0] {
    RegSampleFormat = 2'd0,
    RegMasterVolume = 2'd1,
    RegChannelCount = 2'd2,
    RegRingSamples  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SpkLeft   = 2'd0,
    SpkRight  = 2'd1,
    SpkCentre = 2'd2,
    SpkLfe    = 2'd3
  } speaker_e;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_sample;
    logic [2:0]         channel_index;
    logic               last_channel;
    logic [16:0]        play_position;
  } out_item_t;

  localparam speaker_e SpeakerLayout [8][8] = '{
    '{SpkCentre, SpkLeft, SpkLeft, SpkLeft, SpkLeft, SpkLeft, SpkLeft, SpkLeft},
    '{SpkLeft, SpkRight, SpkLeft, SpkLeft, SpkLeft, SpkLeft, SpkLeft, SpkLeft},
    '{SpkLeft, SpkRight, SpkLfe, SpkLeft, SpkLeft, SpkLeft, SpkLeft, SpkLeft},
    '{SpkLeft, SpkRight, SpkLeft, SpkRight, SpkLeft, SpkLeft, SpkLeft, SpkLeft},
    '{SpkLeft, SpkRight, SpkLfe, SpkLeft, SpkRight, SpkLeft, SpkLeft, SpkLeft},
    '{SpkLeft, SpkRight, SpkCentre, SpkLfe, SpkLeft, SpkRight, SpkLeft, SpkLeft},
    '{SpkLeft, SpkRight, SpkCentre, SpkLfe, SpkCentre, SpkLeft, SpkRight, SpkLeft},
    '{SpkLeft, SpkRight, SpkCentre, SpkLfe, SpkLeft, SpkRight, SpkLeft, SpkRight}
  };

endpackage

// ===== sv/audio_volume_stereo_upmix_unit.sv =====
// Top level of the volume and stereo up-mix unit: input, frame and result registers.
//
//   Channel  Direction  Payload     Handshake
//   in       sink       in_item_t   in_valid_i / in_stall_o
//   out      source     out_item_t  out_valid_o / out_stall_i
//   cfg      sink       APB         psel, penable, pwrite, pready
//
// A frame yields one result per device channel, one per cycle while the output does
// not stall, for channel_count channels (1 to 8) in the frame register, which sets the rate.
// An input transfer passes through the input, frame and result registers before its first result.
// Reset empties all three registers and clears the play position.
// A stall at the output holds the result register and backs up to the input.
module audio_volume_stereo_upmix_unit
  import avsu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  in_item_t            in_data_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output out_item_t           out_data_o,
  input  logic                out_stall_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic [1:0]  fmt_q;
  logic [8:0]  vol_q;
  logic [3:0]  chans_q;
  logic [17:0] ring_q;
  logic        cfg_wr;

  logic        a_valid_q;
  in_item_t    a_item_q;

  logic               b_valid_q;
  logic signed [15:0] b_left_q, b_right_q, b_centre_q, b_lfe_q;
  logic [3:0]         b_count_q;
  logic [2:0]         b_slot_q;
  logic [16:0]        b_pos_q;

  logic        c_valid_q;
  out_item_t   c_item_q;

  logic [16:0] position_q;

  logic        c_free, b_adv, b_last, b_free, a_move, a_load;
  logic [8:0]  vol_eff;
  logic [3:0]  count_eff;
  logic [17:0] ring_eff, pos_base, pos_sum, pos_next;
  logic signed [15:0] left_s, right_s;
  logic signed [16:0] pair_sum, pair_adj;
  logic signed [15:0] centre_s, lfe_s, emit_s;
  speaker_e    spk;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= 2'd0;
      vol_q   <= 9'd256;
      chans_q <= 4'd2;
      ring_q  <= 18'd32768;
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(paddr[3:2]))
        RegSampleFormat: fmt_q   <= pwdata[1:0];
        RegMasterVolume: vol_q   <= pwdata[8:0];
        RegChannelCount: chans_q <= pwdata[3:0];
        RegRingSamples:  ring_q  <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_reg_e'(paddr[3:2]))
      RegSampleFormat: prdata = {30'd0, fmt_q};
      RegMasterVolume: prdata = {23'd0, vol_q};
      RegChannelCount: prdata = {28'd0, chans_q};
      RegRingSamples:  prdata = {14'd0, ring_q};
      default:         prdata = '0;
    endcase
  end

  function automatic logic signed [15:0] scale_sample(logic signed [15:0] raw,
                                                      logic [1:0] fmt,
                                                      logic [8:0] vol);
    logic signed [15:0] x;
    logic signed [25:0] prod;
    logic signed [15:0] y;
    begin
      case (fmt)
        FmtU8:   x = {{8{~raw[7]}}, ~raw[7], raw[6:0]};
        FmtS8:   x = {{8{raw[7]}}, raw[7:0]};
        default: x = raw;
      endcase
      prod = x * $signed({1'b0, vol});
      y = prod[23:8];
      if (fmt == FmtU8) begin
        y = y + 16'sd128;
      end
      scale_sample = y;
    end
  endfunction

  assign c_free = !c_valid_q || !out_stall_i;
  assign b_last = ({1'b0, b_slot_q} == (b_count_q - 4'd1));
  assign b_adv  = b_valid_q && c_free;
  assign b_free = !b_valid_q || (b_adv && b_last);
  assign a_move = a_valid_q && b_free;
  assign in_stall_o = a_valid_q && !b_free;

  assign vol_eff   = (vol_q > 9'd256) ? 9'd256 : vol_q;
  assign count_eff = (chans_q > 4'(MaxChannels)) ? 4'(MaxChannels) : chans_q;
  assign ring_eff  = (ring_q > 18'(RingMax)) ? 18'(RingMax) : ring_q;
  assign a_load    = a_move && (count_eff != 4'd0);

  assign left_s   = scale_sample(a_item_q.left_sample, fmt_q, vol_eff);
  assign right_s  = scale_sample(a_item_q.right_sample, fmt_q, vol_eff);
  assign pair_sum = {left_s[15], left_s} + {right_s[15], right_s};
  assign pair_adj = pair_sum + {16'd0, pair_sum[16]};
  assign centre_s = pair_adj[16:1];
  assign lfe_s    = (fmt_q == FmtU8) ? 16'sd128 : 16'sd0;

  assign pos_base = ({1'b0, position_q} >= ring_eff) ? 18'd0 : {1'b0, position_q};
  assign pos_sum  = pos_base + 18'd2;
  always_comb begin
    if (ring_eff < 18'd2) begin
      pos_next = 18'd0;
    end else if (pos_sum >= ring_eff) begin
      pos_next = pos_sum - ring_eff;
    end else begin
      pos_next = pos_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      a_item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q  <= 1'b0;
      b_slot_q   <= 3'd0;
      position_q <= 17'd0;
    end else begin
      if (b_free) begin
        b_valid_q <= a_load;
        b_slot_q  <= 3'd0;
      end else if (b_adv) begin
        b_slot_q <= b_slot_q + 3'd1;
      end
      if (a_load) begin
        position_q <= pos_next[16:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      b_left_q   <= left_s;
      b_right_q  <= right_s;
      b_centre_q <= centre_s;
      b_lfe_q    <= lfe_s;
      b_count_q  <= count_eff;
      b_pos_q    <= pos_next[16:0];
    end
  end

  assign spk = SpeakerLayout[3'(b_count_q - 4'd1)][b_slot_q];

  always_comb begin
    case (spk)
      SpkLeft:   emit_s = b_left_q;
      SpkRight:  emit_s = b_right_q;
      SpkCentre: emit_s = b_centre_q;
      default:   emit_s = b_lfe_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_free) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      c_item_q.out_sample    <= emit_s;
      c_item_q.channel_index <= b_slot_q;
      c_item_q.last_channel  <= b_last;
      c_item_q.play_position <= b_pos_q;
    end
  end

  assign out_valid_o = c_valid_q;
  assign out_data_o  = c_item_q;

endmodule
